// ===== rtl/core/s2l_pkg.sv =====
// package: shared types, constants and the elaboration-time srgb linearization table
`default_nettype none
package s2l_pkg;

  localparam int FRAC_BITS = 30;
  localparam int CBRT_BITS = 31;

  // lab f() value computed on the linear segment, and whether the cube root wins
  typedef struct packed {
    logic [30:0] f_lin;
    logic        sel;
  } s2l_side_t;

  typedef logic [30:0] lin_tab_t [256];

  // q30 product with rounding, elaboration only
  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

  function automatic logic [63:0] pow5q(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = mulq(r, r);
    r4 = mulq(r2, r2);
    return mulq(r4, r);
  endfunction

  // x^2.4 is formed as x^2 * (x^2)^(1/5)
  function automatic lin_tab_t lin_build();
    lin_tab_t    tab;
    logic [63:0] cc;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int c = 0; c < 256; c++) begin
      cc = 64'(c);
      if (cc * 64'd100000 > 64'd1031475) begin
        x  = (((64'd1000 * cc + 64'd14025) << FRAC_BITS) + 64'd134512) / 64'd269025;
        x2 = mulq(x, x);
        lo = 64'd0;
        hi = 64'd1 << FRAC_BITS;
        for (int i = 0; i < 40; i++) begin
          if (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (pow5q(mid) <= x2) lo = mid;
            else hi = mid - 64'd1;
          end
        end
        tab[c] = 31'(mulq(x2, lo));
      end else begin
        tab[c] = 31'((((cc * 64'd100) << FRAC_BITS) + 64'd164730) / 64'd329460);
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = lin_build();

  // rgb to xyz matrix in units of 1e-4
  localparam logic [13:0] COEF [3][3] = '{
    '{14'd4124, 14'd3576, 14'd1805},
    '{14'd2126, 14'd7152, 14'd722},
    '{14'd193,  14'd1192, 14'd9505}
  };

  // white point divisors, scaled so that all three share one reciprocal form
  localparam logic [16:0] DIV_D [3] = '{17'd95047, 17'd100000, 17'd108883};
  localparam logic [46:0] DIV_K [3] = '{47'd47523, 47'd50000, 47'd54441};
  localparam logic [31:0] DIV_M [3] = '{
    32'((64'd1 << 48) / 64'd95047),
    32'((64'd1 << 48) / 64'd100000),
    32'((64'd1 << 48) / 64'd108883)
  };

  localparam logic [16:0] LIN_D = 17'd100000;
  localparam logic [31:0] LIN_M = 32'((64'd1 << 48) / 64'd100000);

  localparam logic [30:0] F_TH  = 31'((64'd8856 << FRAC_BITS) / 64'd1000000);
  localparam logic [30:0] F_C16 = 31'(((64'd1 << 32) + 64'd14) / 64'd29);

endpackage
`default_nettype wire

// ===== rtl/core/s2l_cbrt.sv =====
// pipelined bit-by-bit q30 cube root, three lanes, two stages per result bit
`default_nettype none
module s2l_cbrt (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [30:0]         t_in [3],
  input  wire s2l_pkg::s2l_side_t  side_in [3],
  output logic                     out_vld,
  output logic [30:0]              root [3],
  output s2l_pkg::s2l_side_t       side_out [3]
);

  localparam int NB = s2l_pkg::CBRT_BITS;

  logic               vb [NB+1];
  logic [30:0]        rb [NB+1][3];
  logic [30:0]        tb [NB+1][3];
  s2l_pkg::s2l_side_t db [NB+1][3];

  logic               va [NB];
  logic [30:0]        ca [NB][3];
  logic [31:0]        sa [NB][3];
  logic [30:0]        ra [NB][3];
  logic [30:0]        ta [NB][3];
  s2l_pkg::s2l_side_t da [NB][3];

  assign vb[0] = in_vld;
  for (genvar l = 0; l < 3; l++) begin : g_in
    assign rb[0][l] = '0;
    assign tb[0][l] = t_in[l];
    assign db[0][l] = side_in[l];
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int BP = NB - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        va[k]   <= 1'b0;
        vb[k+1] <= 1'b0;
      end else if (en) begin
        va[k]   <= vb[k];
        vb[k+1] <= va[k];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [30:0] cand;
      logic [61:0] sq_full;
      logic [62:0] cu_full;
      logic [32:0] cube;

      // try this bit set, square first, cube one stage later
      assign cand    = rb[k][l] | (31'd1 << BP);
      assign sq_full = 62'(cand) * 62'(cand);
      assign cu_full = 63'(sa[k][l]) * 63'(ca[k][l]);
      assign cube    = 33'((cu_full + (63'd1 << (s2l_pkg::FRAC_BITS - 1)))
                           >> s2l_pkg::FRAC_BITS);

      always_ff @(posedge clk) begin
        if (en) begin
          ca[k][l]   <= cand;
          sa[k][l]   <= 32'((sq_full + (62'd1 << (s2l_pkg::FRAC_BITS - 1)))
                            >> s2l_pkg::FRAC_BITS);
          ra[k][l]   <= rb[k][l];
          ta[k][l]   <= tb[k][l];
          da[k][l]   <= db[k][l];
          rb[k+1][l] <= (cube <= 33'(ta[k][l])) ? ca[k][l] : ra[k][l];
          tb[k+1][l] <= ta[k][l];
          db[k+1][l] <= da[k][l];
        end
      end
    end
  end

  assign out_vld = vb[NB];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign root[l]     = rb[NB][l];
    assign side_out[l] = db[NB][l];
  end

endmodule
`default_nettype wire

// ===== rtl/core/srgb_to_cielab.sv =====
// srgb to cielab (d65) pixel converter, top level
// usage:
//   input channel: red, green, blue bytes with in_valid; a request is taken at a
//   rising edge where in_valid is high and in_stall is low
//   output channel: lightness (L*256), green_red (a*256), blue_yellow (b*256)
//   with out_valid; the receiver holds out_stall high to keep a result waiting
//   throughput: one pixel per cycle while no result waits under out_stall;
//   every stage is a register stage; the pipeline does the table lookup,
//   matrix and white point division, then the linear segment of f(), then
//   the cube root (two stages per result bit over 31 bits), then the output
//   formulas and rounding
//   reset clears every valid bit; payload registers keep whatever they hold
//   a stalled result freezes the whole pipeline, so in_stall follows the
//   output stall while a result waits; nothing is lost or repeated
`default_nettype none
module srgb_to_cielab (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [14:0]             lightness,
  output logic signed [15:0]      green_red,
  output logic signed [15:0]      blue_yellow
);

  function automatic logic [30:0] div_est(input logic [46:0] n, input logic [31:0] m);
    logic [62:0] p;
    p = 63'(n[46:16]) * 63'(m);
    return p[62:32];
  endfunction

  function automatic logic [18:0] div_rem(input logic [46:0] n, input logic [30:0] q,
                                          input logic [16:0] d);
    logic [47:0] qd;
    logic [47:0] diff;
    qd   = 48'(q) * 48'(d);
    diff = {1'b0, n} - qd;
    return diff[18:0];
  endfunction

  // estimate is low by at most three
  function automatic logic [30:0] div_fix(input logic [30:0] q, input logic [18:0] rem,
                                          input logic [16:0] d);
    logic [1:0] adj;
    adj = 2'(rem >= 19'(d)) + 2'(rem >= 19'({d, 1'b0}))
        + 2'(rem >= 19'(20'({d, 1'b0}) + 20'(d)));
    return q + 31'(adj);
  endfunction

  function automatic logic signed [19:0] to_q8(input logic signed [40:0] v);
    logic [40:0] mag;
    logic [18:0] rq;
    mag = v[40] ? 41'(-v) : 41'(v);
    rq  = 19'((mag + (41'd1 << 21)) >> 22);
    return v[40] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
  endfunction

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  logic [7:0] pix [3];
  assign pix[0] = red;
  assign pix[1] = green;
  assign pix[2] = blue;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;
  logic [30:0]        lin1 [3];
  logic [44:0]        p2   [3][3];
  logic [46:0]        n3   [3];
  logic [30:0]        q4   [3];
  logic [46:0]        n4   [3];
  logic [30:0]        q5   [3];
  logic [18:0]        rem5 [3];
  logic [30:0]        t6   [3];
  logic [30:0]        t7   [3];
  logic               sel7 [3];
  logic [46:0]        n7   [3];
  logic [30:0]        t8   [3];
  logic               sel8 [3];
  logic [30:0]        q8   [3];
  logic [46:0]        n8   [3];
  logic [30:0]        t9   [3];
  logic               sel9 [3];
  logic [30:0]        q9   [3];
  logic [18:0]        rem9 [3];
  logic [30:0]        t10  [3];
  s2l_pkg::s2l_side_t side10 [3];

  logic               vc;
  logic [30:0]        rc [3];
  s2l_pkg::s2l_side_t sc [3];
  logic [30:0]        f  [3];

  logic signed [40:0] lq11, aq11, bq11;
  logic signed [40:0] fxs, fys, fzs;
  logic signed [19:0] l20, a20, b20;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= vc;
      out_valid <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lin1[i] <= s2l_pkg::LIN_TAB[pix[i]];
        for (int j = 0; j < 3; j++) begin
          p2[i][j] <= 45'(s2l_pkg::COEF[i][j]) * 45'(lin1[j]);
        end
        // times ten plus rounding offset, then divide by the scaled white point
        n3[i] <= (47'(p2[i][0]) + 47'(p2[i][1]) + 47'(p2[i][2])) * 47'd10
                 + s2l_pkg::DIV_K[i];
        q4[i]   <= div_est(n3[i], s2l_pkg::DIV_M[i]);
        n4[i]   <= n3[i];
        rem5[i] <= div_rem(n4[i], q4[i], s2l_pkg::DIV_D[i]);
        q5[i]   <= q4[i];
        t6[i]   <= div_fix(q5[i], rem5[i], s2l_pkg::DIV_D[i]);
        // linear segment 7.787 t, only meaningful below the threshold
        t7[i]   <= t6[i];
        sel7[i] <= t6[i] > s2l_pkg::F_TH;
        n7[i]   <= (t6[i] > s2l_pkg::F_TH) ? 47'd50000
                   : 47'(t6[i]) * 47'd778700 + 47'd50000;
        t8[i]   <= t7[i];
        sel8[i] <= sel7[i];
        q8[i]   <= div_est(n7[i], s2l_pkg::LIN_M);
        n8[i]   <= n7[i];
        t9[i]   <= t8[i];
        sel9[i] <= sel8[i];
        q9[i]   <= q8[i];
        rem9[i] <= div_rem(n8[i], q8[i], s2l_pkg::LIN_D);
        t10[i]  <= t9[i];
        side10[i].sel   <= sel9[i];
        side10[i].f_lin <= div_fix(q9[i], rem9[i], s2l_pkg::LIN_D) + s2l_pkg::F_C16;
      end
    end
  end

  s2l_cbrt u_cbrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v10),
    .t_in     (t10),
    .side_in  (side10),
    .out_vld  (vc),
    .root     (rc),
    .side_out (sc)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f[i] = sc[i].sel ? rc[i] : sc[i].f_lin;
    end
  end

  assign fxs = $signed(41'(f[0]));
  assign fys = $signed(41'(f[1]));
  assign fzs = $signed(41'(f[2]));

  assign l20 = to_q8(lq11);
  assign a20 = to_q8(aq11);
  assign b20 = to_q8(bq11);

  always_ff @(posedge clk) begin
    if (en) begin
      lq11 <= fys * 41'sd116 - 41'sd17179869184;
      aq11 <= (fxs - fys) * 41'sd500;
      bq11 <= (fys - fzs) * 41'sd200;

      if (l20 < 20'sd0) lightness <= 15'd0;
      else if (l20 > 20'sd25600) lightness <= 15'd25600;
      else lightness <= 15'(l20);

      if (a20 > 20'sd32767) green_red <= 16'sh7fff;
      else if (a20 < -20'sd32768) green_red <= -16'sh8000;
      else green_red <= 16'(a20);

      if (b20 > 20'sd32767) blue_yellow <= 16'sh7fff;
      else if (b20 < -20'sd32768) blue_yellow <= -16'sh8000;
      else blue_yellow <= 16'(b20);
    end
  end

`ifndef SYNTHESIS
  a_l_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lightness <= 15'd25600)
    else $error("lightness out of range");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !vc)
    else $error("valid bits not cleared by reset");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted request not captured in the first stage");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v11) && $stable(vc) && $stable(v10))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule
`default_nettype wire
